>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the queue RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property on clk, switched off while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked implication, antecedent then consequent on the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/dpeq_pkg.sv
// ----------------------------------------------------------------------------
// dpeq_pkg
// Shared types and constants for the deduplicating pending event queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dpeq_pkg;

  localparam int EVENT_COUNT_DEF = 64;
  localparam int EV_W            = 6;
  localparam int COUNT_W         = 7;
  localparam int MASK_W          = 64;
  localparam int IN_DATA_W       = 8;
  localparam int OUT_DATA_W      = 16;

  localparam logic [1:0] OP_POST = 2'd0;
  localparam logic [1:0] OP_TAKE = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;

  // Per-cycle command broadcast along the cell chain
  typedef struct packed {
    logic            take;
    logic            post;
    logic [EV_W-1:0] post_ev;
  } cell_ctrl_t;

endpackage

>>> hdl/dedup_pending_event_queue_top.sv
// ----------------------------------------------------------------------------
// dedup_pending_event_queue_top
// Result appears on m_axis in the cycle after the input transaction.
// Throughput: one transaction per cycle while m_axis does not stall; the cell
// chain shifts or fills per transaction; s_axis_tready follows m_axis_tready.
// Reset: rst clears the chain valid bits, pending bitmap, count and mask;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dedup_pending_event_queue_top #(
  parameter int EVENT_COUNT = dpeq_pkg::EVENT_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [dpeq_pkg::MASK_W-1:0]     cfg_wr_data,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [1:0] opcode, [7:2] event_number
  input  logic [dpeq_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [5:0] head_event, [6] head_valid, [7] appended, [14:8] pending_count,
  // [15] zero
  output logic [dpeq_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import dpeq_pkg::*;

  localparam int IDX_W = (EVENT_COUNT > 1) ? $clog2(EVENT_COUNT) : 1;
  localparam int CNT_W = $clog2(EVENT_COUNT + 1);

  logic [MASK_W-1:0]      enabled_events;
  logic [EVENT_COUNT-1:0] pending;
  logic [CNT_W-1:0]       count;

  logic [1:0]      op;
  logic [EV_W-1:0] ev;
  logic [IDX_W-1:0] ev_idx;
  logic [IDX_W-1:0] head_idx;
  logic            in_acc;
  logic            ev_in_range;
  logic            post_ok;
  logic            take_ok;
  logic            read_op;

  cell_ctrl_t      ctrl;
  logic            head_valid;
  logic [EV_W-1:0] head_ev;

  logic [CNT_W-1:0] count_next;

  logic [EV_W-1:0]    out_head;
  logic               out_hvalid;
  logic               out_appended;
  logic [COUNT_W-1:0] out_count;

  assign op       = s_axis_tdata[1:0];
  assign ev       = s_axis_tdata[7:2];
  assign ev_idx   = ev[IDX_W-1:0];
  assign head_idx = head_ev[IDX_W-1:0];

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign ev_in_range = ({1'b0, ev} < (EV_W+1)'(EVENT_COUNT));
  assign read_op     = (op == OP_TAKE) || (op == OP_PEEK);
  assign post_ok     = in_acc && (op == OP_POST) && ev_in_range && enabled_events[ev]
                       && !pending[ev_idx] && (count < CNT_W'(EVENT_COUNT));
  assign take_ok     = in_acc && (op == OP_TAKE) && head_valid;

  assign ctrl.take    = take_ok;
  assign ctrl.post    = post_ok;
  assign ctrl.post_ev = ev;

  dpeq_chain #(
    .DEPTH (EVENT_COUNT)
  ) u_chain (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .head_valid (head_valid),
    .head_ev    (head_ev)
  );

  always_comb begin
    count_next = count;
    if (post_ok) begin
      count_next = count + 1'b1;
    end else if (take_ok) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled_events <= '0;
      pending        <= '0;
      count          <= '0;
    end else begin
      if (cfg_wr_en) begin
        enabled_events <= cfg_wr_data;
      end
      if (post_ok) begin
        pending[ev_idx] <= 1'b1;
      end
      if (take_ok) begin
        pending[head_idx] <= 1'b0;
      end
      count <= count_next;
    end
  end

  // Output register: valid under reset, payload loaded on each transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_acc) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_head     <= (read_op && head_valid) ? head_ev : '0;
      out_hvalid   <= read_op && head_valid;
      out_appended <= post_ok;
      out_count    <= COUNT_W'(count_next);
    end
  end

  assign m_axis_tdata = {1'b0, out_count, out_appended, out_hvalid, out_head};

  // Chain occupancy, bitmap and counter must agree
  `ASSERT_CLK(a_head_vs_count, head_valid == (count != '0), "head valid disagrees with count")
  `ASSERT_CLK(a_bitmap_vs_count, $countones(pending) == int'(count), "bitmap disagrees with count")
  `ASSERT_NEXT(a_take_dec, take_ok, count == $past(count) - 1'b1, "take did not decrement count")

endmodule

>>> hdl/dpeq_cell.sv
// ----------------------------------------------------------------------------
// dpeq_cell
// One queue slot: shifts towards the head on a take, claims a post when it is
// the first empty slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dpeq_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  dpeq_pkg::cell_ctrl_t      ctrl,
  input  logic                      below_valid,
  input  logic                      above_valid,
  input  logic [dpeq_pkg::EV_W-1:0] above_ev,
  output logic                      valid,
  output logic [dpeq_pkg::EV_W-1:0] ev
);
  import dpeq_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.take) begin
      valid <= above_valid;
    end else if (ctrl.post && !valid && below_valid) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      ev <= above_ev;
    end else if (ctrl.post && !valid && below_valid) begin
      ev <= ctrl.post_ev;
    end
  end

endmodule

>>> hdl/dpeq_chain.sv
// ----------------------------------------------------------------------------
// dpeq_chain
// Row of queue cells; cell 0 holds the oldest pending event.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dpeq_chain #(
  parameter int DEPTH = dpeq_pkg::EVENT_COUNT_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  dpeq_pkg::cell_ctrl_t      ctrl,
  output logic                      head_valid,
  output logic [dpeq_pkg::EV_W-1:0] head_ev
);
  import dpeq_pkg::*;

  logic [DEPTH-1:0] cell_valid;
  logic [EV_W-1:0]  cell_ev [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic            below_v;
    logic            above_v;
    logic [EV_W-1:0] above_e;

    if (i == 0) begin : g_first
      assign below_v = 1'b1;
    end else begin : g_mid
      assign below_v = cell_valid[i-1];
    end

    if (i == DEPTH-1) begin : g_last
      assign above_v = 1'b0;
      assign above_e = '0;
    end else begin : g_inner
      assign above_v = cell_valid[i+1];
      assign above_e = cell_ev[i+1];
    end

    dpeq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .below_valid (below_v),
      .above_valid (above_v),
      .above_ev    (above_e),
      .valid       (cell_valid[i]),
      .ev          (cell_ev[i])
    );
  end

  assign head_valid = cell_valid[0];
  assign head_ev    = cell_ev[0];

endmodule
